// ===== sv/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 stream validator: beat payloads,
// lead byte classes, continuation range rules and queue sizing.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned CountW   = 16;
  localparam logic [CountW-1:0] MaxBytes = 16'hFFFF;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    RULE_PLAIN = 3'd0,
    RULE_A0_BF = 3'd1,
    RULE_80_9F = 3'd2,
    RULE_90_BF = 3'd3,
    RULE_80_8F = 3'd4
  } utf8v_rule_e;

  localparam int unsigned NumRules = 5;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } utf8v_lead_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } utf8v_in_t;

  typedef struct packed {
    logic              status;
    logic [CountW-1:0] error_position;
  } utf8v_out_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic                has_byte;
    logic                last;
    utf8v_lead_e         lead;
    utf8v_rule_e         rule;
    logic [NumRules-1:0] cont_ok;
  } utf8v_entry_t;

endpackage

// ===== sv/utf8v_front.sv =====
// ----------------------------------------------------------------------------
// utf8v_front
// Accepts input beats and classifies each byte: lead class, second byte
// rule for the lead, and range checks against every continuation rule.
// ----------------------------------------------------------------------------
module utf8v_front (
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  utf8v_pkg::utf8v_in_t    in_data_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output utf8v_pkg::utf8v_entry_t q_data_o
);
  import utf8v_pkg::*;

  logic [7:0] b;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o          = '0;
    q_data_o.has_byte = in_data_i.has_byte;
    q_data_o.last     = in_data_i.last;
    q_data_o.rule     = RULE_PLAIN;
    q_data_o.lead     = LEAD_BAD;
    if (b <= 8'h7F) begin
      q_data_o.lead = LEAD_ASCII;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      q_data_o.lead = LEAD_TWO;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      q_data_o.lead = LEAD_THREE;
      if (b == 8'hE0) q_data_o.rule = RULE_A0_BF;
      else if (b == 8'hED) q_data_o.rule = RULE_80_9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      q_data_o.lead = LEAD_FOUR;
      if (b == 8'hF0) q_data_o.rule = RULE_90_BF;
      else if (b == 8'hF4) q_data_o.rule = RULE_80_8F;
    end
    q_data_o.cont_ok[RULE_PLAIN] = (b >= 8'h80 && b <= 8'hBF);
    q_data_o.cont_ok[RULE_A0_BF] = (b >= 8'hA0 && b <= 8'hBF);
    q_data_o.cont_ok[RULE_80_9F] = (b >= 8'h80 && b <= 8'h9F);
    q_data_o.cont_ok[RULE_90_BF] = (b >= 8'h90 && b <= 8'hBF);
    q_data_o.cont_ok[RULE_80_8F] = (b >= 8'h80 && b <= 8'h8F);
  end

endmodule

// ===== sv/utf8v_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8v_fifo
// Short queue of classified beats between the front and back parts.
// ----------------------------------------------------------------------------
module utf8v_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  utf8v_pkg::utf8v_entry_t push_data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output utf8v_pkg::utf8v_entry_t pop_data_o
);
  import utf8v_pkg::*;

  utf8v_entry_t        mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/utf8v_back.sv =====
// ----------------------------------------------------------------------------
// utf8v_back
// Tracks sequence state per classified beat and registers the result of
// each string into the output slot.
// ----------------------------------------------------------------------------
module utf8v_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  utf8v_pkg::utf8v_entry_t q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output utf8v_pkg::utf8v_out_t   out_data_o
);
  import utf8v_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] lead_q, lead_d;
  logic [1:0]        pend_q, pend_d;
  utf8v_rule_e       rule_q, rule_d;
  logic              err_q, err_d;
  logic [CountW-1:0] ferr_q, ferr_d;
  logic              out_valid_q, out_valid_d;
  utf8v_out_t        out_q, out_d;
  logic              take;
  logic              ok;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign take        = q_pop_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (rule_q)
      RULE_A0_BF: ok = q_data_i.cont_ok[RULE_A0_BF];
      RULE_80_9F: ok = q_data_i.cont_ok[RULE_80_9F];
      RULE_90_BF: ok = q_data_i.cont_ok[RULE_90_BF];
      RULE_80_8F: ok = q_data_i.cont_ok[RULE_80_8F];
      default:    ok = q_data_i.cont_ok[RULE_PLAIN];
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    lead_d      = lead_q;
    pend_d      = pend_q;
    rule_d      = rule_q;
    err_d       = err_q;
    ferr_d      = ferr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      if (q_data_i.has_byte) begin
        if (cnt_q != MaxBytes) cnt_d = cnt_q + 1'b1;
        if (!err_q) begin
          if (pend_q != 2'd0) begin
            rule_d = RULE_PLAIN;
            if (ok) begin
              pend_d = pend_q - 1'b1;
            end else begin
              err_d  = 1'b1;
              ferr_d = lead_q;
              pend_d = 2'd0;
            end
          end else begin
            lead_d = cnt_d;
            rule_d = q_data_i.rule;
            unique case (q_data_i.lead)
              LEAD_ASCII: pend_d = 2'd0;
              LEAD_TWO:   pend_d = 2'd1;
              LEAD_THREE: pend_d = 2'd2;
              LEAD_FOUR:  pend_d = 2'd3;
              default: begin
                err_d  = 1'b1;
                ferr_d = cnt_d;
                pend_d = 2'd0;
                rule_d = RULE_PLAIN;
              end
            endcase
          end
        end
      end
      if (q_data_i.last) begin
        out_valid_d = 1'b1;
        out_d.status = err_d || (pend_d != 2'd0);
        if (err_d) out_d.error_position = ferr_d;
        else if (pend_d != 2'd0) out_d.error_position = lead_d;
        else out_d.error_position = '0;
        cnt_d  = '0;
        lead_d = '0;
        pend_d = 2'd0;
        rule_d = RULE_PLAIN;
        err_d  = 1'b0;
        ferr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lead_q      <= '0;
      pend_q      <= 2'd0;
      rule_q      <= RULE_PLAIN;
      err_q       <= 1'b0;
      ferr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      lead_q      <= lead_d;
      pend_q      <= pend_d;
      rule_q      <= rule_d;
      err_q       <= err_d;
      ferr_q      <= ferr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== sv/utf8_stream_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte string, one byte per beat, for well-formed UTF-8.
// ----------------------------------------------------------------------------
// Takes one byte per clock, sustained, while the result side keeps up. Each
// beat is classified on entry and placed in a four-beat queue; the sequence
// tracker drains that queue at one beat per cycle, unless the output is held
// stalled, into a single output register, so a string's result appears in
// the cycle after its last beat is taken. The input stalls only when the
// queue is full, which happens when the output is held stalled. Status 0
// means well formed; otherwise error_position is the 1-based position of the
// lead byte of the first bad or truncated sequence, saturating at 65535.
module utf8_stream_validator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8v_pkg::utf8v_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output utf8v_pkg::utf8v_out_t out_data_o
);
  import utf8v_pkg::*;

  utf8v_entry_t push_data, pop_data;
  logic         push, pop, full, empty;

  utf8v_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  utf8v_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  utf8v_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
